### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/rhh_pkg.sv
`timescale 1ns / 1ps

package rhh_pkg;

  // Default sizing of the table.
  localparam int MAX_LOG2_SIZE_DEF = 10;
  localparam int PROBE_SLACK_DEF   = 32;
  localparam logic [3:0] LOG2_SIZE_RESET = 4'd8;

  // Fixed widths of the result fields.
  localparam int IDX_W = 11;

  // Fibonacci hashing multiplier.
  localparam logic [63:0] FIB_MULT = 64'd11400714819323198485;

  // Operation codes; the spare code is answered as a get.
  localparam logic [1:0] OP_GET    = 2'd0;
  localparam logic [1:0] OP_PUT    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_INSERTED  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // One result beat as it leaves the engine.
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] bucket;
    logic [63:0]      value;
    logic [IDX_W-1:0] count;
  } rhh_result_t;

endpackage

### sv/rhh_hash.sv
`timescale 1ns / 1ps

module rhh_hash import rhh_pkg::*; #(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [63:0]                        key,
  input  logic [$clog2(MAX_LOG2_SIZE+1)-1:0] l_eff,
  output logic                               done,
  output logic [MAX_LOG2_SIZE-1:0]           home,
  output logic [6:0]                         tag
);

  typedef enum logic [2:0] {H_IDLE, H_MUL0, H_MUL1, H_MUL2, H_SUM, H_OUT} phase_t;

  phase_t      phase;
  logic [63:0] x;
  logic [63:0] pp;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [5:0]  sh;
  logic [6:0]  hs;
  logic [63:0] home_sh;
  logic [63:0] tag_sh;

  // Shift amounts follow the table size.
  assign sh = 6'(7'd57 - 7'(l_eff));
  assign hs = 7'(8'd64 - 8'(l_eff));

  assign home_sh = acc >> hs;
  assign tag_sh  = acc >> sh;

  // One 32 by 32 multiplier serves the three partial products of the low word.
  always_comb begin
    case (phase)
      H_MUL1: begin
        mul_a = x[63:32];
        mul_b = FIB_MULT[31:0];
      end
      H_MUL2: begin
        mul_a = x[31:0];
        mul_b = FIB_MULT[63:32];
      end
      default: begin
        mul_a = x[31:0];
        mul_b = FIB_MULT[31:0];
      end
    endcase
  end

  // Mix, multiply in H_MUL0 to H_MUL2, sum in H_SUM, then take home bucket and tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= H_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        H_IDLE: begin
          if (start) begin
            x     <= key ^ (key >> sh);
            phase <= H_MUL0;
          end
        end
        H_MUL0: begin
          pp    <= 64'(mul_a) * 64'(mul_b);
          phase <= H_MUL1;
        end
        H_MUL1: begin
          acc   <= pp;
          pp    <= 64'(mul_a) * 64'(mul_b);
          phase <= H_MUL2;
        end
        H_MUL2: begin
          acc[63:32] <= acc[63:32] + pp[31:0];
          pp         <= 64'(mul_a) * 64'(mul_b);
          phase      <= H_SUM;
        end
        H_SUM: begin
          acc[63:32] <= acc[63:32] + pp[31:0];
          phase      <= H_OUT;
        end
        H_OUT: begin
          home  <= home_sh[MAX_LOG2_SIZE-1:0];
          tag   <= tag_sh[6:0];
          done  <= 1'b1;
          phase <= H_IDLE;
        end
        default: phase <= H_IDLE;
      endcase
    end
  end

endmodule

### sv/rhh_engine.sv
`timescale 1ns / 1ps

module rhh_engine import rhh_pkg::*; #(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  parameter int PROBE_SLACK   = PROBE_SLACK_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               clr,
  input  logic [$clog2(MAX_LOG2_SIZE+1)-1:0] l_eff,
  input  logic                               start,
  input  logic [1:0]                         req_op,
  input  logic [63:0]                        req_key,
  input  logic [63:0]                        req_value,
  output logic                               ready,
  output logic                               res_valid,
  input  logic                               res_ready,
  output rhh_result_t                        res
);

  localparam int CAP_MAX = (1 << MAX_LOG2_SIZE) + PROBE_SLACK;
  localparam int AW      = $clog2(CAP_MAX);
  localparam int IW      = $clog2(CAP_MAX + 1);
  localparam logic [IW-1:0] CAP_MAX_I = IW'(CAP_MAX);

  typedef struct packed {
    logic          used;
    logic [6:0]    tag;
    logic [IW-1:0] disp;
    logic [IW-1:0] slot;
  } bkt_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_HASH, S_SCAN_RD, S_SCAN_CHK, S_KEY_CHK, S_DISPATCH,
    S_INS_HI, S_INS_CMP, S_INS_FIN, S_REL_RD, S_REL_HASH,
    S_SH_START, S_SH_CHK, S_SH_END, S_DONE
  } state_t;

  typedef enum logic [1:0] {SR_FOUND, SR_EMPTY, SR_END} sres_t;

  // Bucket memory and key/value store.
  bkt_t  bmem [CAP_MAX];
  slot_t smem [CAP_MAX];

  bkt_t          brd;
  slot_t         srd;
  logic          b_we;
  logic [AW-1:0] b_waddr;
  logic [AW-1:0] b_raddr;
  bkt_t          b_wdata;
  logic          s_we;
  logic [AW-1:0] s_waddr;
  logic [AW-1:0] s_raddr;
  slot_t         s_wdata;

  state_t        state;
  sres_t         sres;
  logic [1:0]    op;
  logic [63:0]   key;
  logic [63:0]   value;
  logic [IW-1:0] home;
  logic [6:0]    tag;
  logic          rel_mode;
  logic [IW-1:0] b;
  logic [IW-1:0] cand;
  logic [IW-1:0] pos;
  logic [IW-1:0] fslot;
  logic [IW-1:0] rm_pos;
  logic [IW-1:0] rm_slot;
  logic [IW-1:0] top;
  logic [IW-1:0] clr_cnt;
  bkt_t          rec_hi;
  bkt_t          srec;
  logic [63:0]   tk;
  logic [63:0]   tv;
  logic [1:0]    res_status;
  logic [IW-1:0] res_bucket;
  logic [63:0]   res_value;

  logic                     h_start;
  logic [63:0]              h_key;
  logic                     h_done;
  logic [MAX_LOG2_SIZE-1:0] h_home;
  logic [6:0]               h_tag;

  logic [IW-1:0] cap;
  logic [IW:0]   cap_x;
  logic [IW:0]   b_p1;
  logic [IW:0]   b_p2;
  logic [IW-1:0] b_m1;
  logic [IW-1:0] b_m2;
  logic [IW-1:0] pos_m1;
  logic [IW-1:0] pos_m2;
  logic [IW-1:0] top_m1;
  logic [63:0]   scan_key;
  logic          rel_go;
  logic          put_ok;
  logic          mv;

  rhh_hash #(
    .MAX_LOG2_SIZE(MAX_LOG2_SIZE)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (h_start),
    .key   (h_key),
    .l_eff (l_eff),
    .done  (h_done),
    .home  (h_home),
    .tag   (h_tag)
  );

  // Memory ports: one write and one registered read each.
  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[b_waddr] <= b_wdata;
    end
    brd <= bmem[b_raddr];
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    srd <= smem[s_raddr];
  end

  // Address arithmetic shared by the walks.
  assign cap      = (IW'(1) << l_eff) + IW'(PROBE_SLACK);
  assign cap_x    = {1'b0, cap};
  assign b_p1     = {1'b0, b} + (IW+1)'(1);
  assign b_p2     = {1'b0, b} + (IW+1)'(2);
  assign b_m1     = b - IW'(1);
  assign b_m2     = b - IW'(2);
  assign pos_m1   = pos - IW'(1);
  assign pos_m2   = pos - IW'(2);
  assign top_m1   = top - IW'(1);
  assign scan_key = rel_mode ? tk : key;
  assign rel_go   = (top != '0) && (top_m1 != '0) && (top_m1 != fslot) && (fslot < CAP_MAX_I);
  assign put_ok   = top < CAP_MAX_I;
  assign mv       = rec_hi.disp <= brd.disp;

  // Memory control for each step of the sequencer.
  always_comb begin
    b_we    = 1'b0;
    b_waddr = '0;
    b_wdata = '0;
    b_raddr = b[AW-1:0];
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = '0;
    h_start = 1'b0;
    h_key   = req_key;
    case (state)
      S_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_cnt[AW-1:0];
      end
      S_IDLE: begin
        h_start = start;
      end
      S_SCAN_CHK: begin
        s_raddr = brd.slot[AW-1:0];
      end
      S_DISPATCH: begin
        if (!rel_mode) begin
          if (op == OP_PUT) begin
            if (sres == SR_FOUND) begin
              s_we    = 1'b1;
              s_waddr = fslot[AW-1:0];
              s_wdata = '{key: key, value: value};
            end else if (sres == SR_EMPTY && put_ok) begin
              b_raddr = pos_m1[AW-1:0];
            end
          end else if (op == OP_REMOVE && sres == SR_FOUND && rel_go) begin
            s_raddr = top_m1[AW-1:0];
          end
        end else begin
          if (sres == SR_FOUND) begin
            b_we         = 1'b1;
            b_waddr      = pos[AW-1:0];
            b_wdata      = srec;
            b_wdata.slot = rm_slot;
          end
          s_we    = 1'b1;
          s_waddr = rm_slot[AW-1:0];
          s_wdata = '{key: tk, value: tv};
        end
      end
      S_INS_HI: begin
        b_raddr = pos_m2[AW-1:0];
      end
      S_INS_CMP: begin
        if (mv) begin
          b_we         = 1'b1;
          b_waddr      = cand[AW-1:0];
          b_wdata      = rec_hi;
          b_wdata.disp = rec_hi.disp + cand - b;
        end
        b_raddr = b_m2[AW-1:0];
      end
      S_INS_FIN: begin
        b_we    = 1'b1;
        b_waddr = cand[AW-1:0];
        b_wdata = '{used: 1'b1, tag: tag, disp: cand - home, slot: top};
        s_we    = 1'b1;
        s_waddr = top[AW-1:0];
        s_wdata = '{key: key, value: value};
      end
      S_REL_RD: begin
        h_start = 1'b1;
        h_key   = srd.key;
      end
      S_SH_START: begin
        if (b_p1 < cap_x) begin
          b_raddr = b_p1[AW-1:0];
        end else begin
          b_we    = 1'b1;
          b_waddr = b[AW-1:0];
        end
      end
      S_SH_CHK: begin
        b_we    = 1'b1;
        b_waddr = b[AW-1:0];
        if (brd.disp != '0) begin
          b_wdata      = brd;
          b_wdata.disp = brd.disp - IW'(1);
          b_raddr      = b_p2[AW-1:0];
        end
      end
      S_SH_END: begin
        b_we    = 1'b1;
        b_waddr = b[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Sequencer: hash, probe, then update, insert shift or removal shift.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      top     <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == CAP_MAX_I - IW'(1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            op    <= req_op;
            key   <= req_key;
            value <= req_value;
            state <= S_HASH;
          end
        end
        S_HASH, S_REL_HASH: begin
          if (h_done) begin
            home     <= IW'(h_home);
            tag      <= h_tag;
            b        <= IW'(h_home);
            rel_mode <= (state == S_REL_HASH);
            state    <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (b >= cap) begin
            sres  <= SR_END;
            state <= S_DISPATCH;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (!brd.used) begin
            sres  <= SR_EMPTY;
            pos   <= b;
            state <= S_DISPATCH;
          end else if (brd.tag == tag && brd.slot < CAP_MAX_I) begin
            srec  <= brd;
            fslot <= brd.slot;
            state <= S_KEY_CHK;
          end else begin
            b     <= b + IW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_KEY_CHK: begin
          if (srd.key == scan_key) begin
            sres <= SR_FOUND;
            pos  <= b;
            if (!rel_mode) begin
              res_value <= srd.value;
            end
            state <= S_DISPATCH;
          end else begin
            b     <= b + IW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_DISPATCH: begin
          if (!rel_mode) begin
            res_status <= ST_NOT_FOUND;
            res_bucket <= '0;
            if (!(op != OP_PUT && op != OP_REMOVE && sres == SR_FOUND)) begin
              res_value <= '0;
            end
            state <= S_DONE;
            if (op == OP_PUT) begin
              if (sres == SR_FOUND) begin
                res_status <= ST_FOUND;
                res_bucket <= pos;
              end else if (sres == SR_EMPTY && put_ok) begin
                cand <= pos;
                if (pos == home) begin
                  state <= S_INS_FIN;
                end else begin
                  state <= S_INS_HI;
                end
              end else begin
                res_status <= ST_FULL;
              end
            end else if (op == OP_REMOVE) begin
              if (sres == SR_FOUND) begin
                res_status <= ST_FOUND;
                res_bucket <= pos;
                rm_pos     <= pos;
                rm_slot    <= fslot;
                if (top != '0) begin
                  top <= top_m1;
                end
                if (rel_go) begin
                  state <= S_REL_RD;
                end else begin
                  b     <= pos;
                  state <= S_SH_START;
                end
              end
            end else if (sres == SR_FOUND) begin
              res_status <= ST_FOUND;
              res_bucket <= pos;
            end
          end else begin
            b     <= rm_pos;
            state <= S_SH_START;
          end
        end
        S_INS_HI: begin
          rec_hi <= brd;
          b      <= pos_m1;
          if (pos_m1 == home) begin
            state <= S_INS_FIN;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (mv) begin
            cand <= b;
          end
          rec_hi <= brd;
          b      <= b_m1;
          if (b_m1 == home) begin
            state <= S_INS_FIN;
          end
        end
        S_INS_FIN: begin
          top        <= top + IW'(1);
          res_status <= ST_INSERTED;
          res_bucket <= cand;
          state      <= S_DONE;
        end
        S_REL_RD: begin
          tk    <= srd.key;
          tv    <= srd.value;
          state <= S_REL_HASH;
        end
        S_SH_START: begin
          if (b_p1 < cap_x) begin
            state <= S_SH_CHK;
          end else begin
            state <= S_DONE;
          end
        end
        S_SH_CHK: begin
          if (brd.disp != '0) begin
            b <= b + IW'(1);
            if (!(b_p2 < cap_x)) begin
              state <= S_SH_END;
            end
          end else begin
            state <= S_DONE;
          end
        end
        S_SH_END: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ready      = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.status = res_status;
  assign res.bucket = IDX_W'(res_bucket);
  assign res.value  = res_value;
  assign res.count  = IDX_W'(top);

endmodule

### sv/robin_hood_hash_table_core.sv
`timescale 1ns / 1ps
// Robin Hood key/value table with Fibonacci hashing. One beat in carries an
// operation (get, put or remove) with a 64-bit key and value; one beat out
// answers it. Each operation passes acceptance, hashing, a probe of buckets
// from home (reading the stored key where the tag matches), dispatch and
// hand-off; a put of a new key adds a walk over the buckets from home up to
// and including the empty bucket, and a remove adds a second hash and probe
// for the entry that moves into the freed store slot, then a shift back of
// the displaced buckets behind the removed entry. The bucket memory has a
// single read port. After reset and after every write of log2_size the
// bucket memory is swept clear, one bucket a cycle, over all 2^MAX_LOG2_SIZE
// + PROBE_SLACK buckets (1056 by default), and no beat is taken meanwhile.

`include "assert_macros.svh"

module robin_hood_hash_table_core import rhh_pkg::*; #(
  parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
  parameter int PROBE_SLACK   = PROBE_SLACK_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [3:0]   cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // key [63:0], new_value [127:64]
  input  logic [1:0]   s_axis_tuser,   // opcode [1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [87:0]  m_axis_tdata,   // bucket_index [10:0], found_value [74:11],
                                       // entry_count [85:75], zero [87:86]
  output logic [1:0]   m_axis_tuser    // status [1:0]
);

  localparam int LW = $clog2(MAX_LOG2_SIZE + 1);
  localparam logic [LW-1:0] MAX_L = LW'(MAX_LOG2_SIZE);

  logic [3:0]    log2_size;
  logic [LW-1:0] l_eff;
  logic          eng_ready;
  logic          eng_res_valid;
  logic          eng_res_ready;
  rhh_result_t   eng_res;
  rhh_result_t   out_res;

  // Size register; every write clears the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_size <= LOG2_SIZE_RESET;
    end else if (cfg_we) begin
      log2_size <= cfg_data;
    end
  end

  // Clamp the size into the supported range.
  always_comb begin
    if (log2_size == 4'd0) begin
      l_eff = LW'(1);
    end else if (32'(log2_size) > 32'(MAX_LOG2_SIZE)) begin
      l_eff = MAX_L;
    end else begin
      l_eff = LW'(log2_size);
    end
  end

  rhh_engine #(
    .MAX_LOG2_SIZE(MAX_LOG2_SIZE),
    .PROBE_SLACK  (PROBE_SLACK)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_we),
    .l_eff     (l_eff),
    .start     (s_axis_tvalid),
    .req_op    (s_axis_tuser),
    .req_key   (s_axis_tdata[63:0]),
    .req_value (s_axis_tdata[127:64]),
    .ready     (eng_ready),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res       (eng_res)
  );

  assign s_axis_tready = eng_ready;

  // Output register; the engine moves on while a result beat waits.
  assign eng_res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (eng_res_valid && eng_res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_valid && eng_res_ready) begin
      out_res <= eng_res;
    end
  end

  assign m_axis_tdata = {2'b00, out_res.count, out_res.value, out_res.bucket};
  assign m_axis_tuser = out_res.status;

  // A size write starts the clearing sweep, so no beat is taken next.
  `ASSERT_NEXT(a_cfg_blocks_input, clk, rst, cfg_we, !s_axis_tready)
  // A miss or a full table reports bucket zero.
  `ASSERT_IMPL(a_miss_bucket_zero, clk, rst,
               m_axis_tvalid && (m_axis_tuser == ST_NOT_FOUND || m_axis_tuser == ST_FULL),
               m_axis_tdata[10:0] == '0)
  // Only a hit carries a value.
  `ASSERT_IMPL(a_value_on_hit, clk, rst,
               m_axis_tvalid && (m_axis_tdata[74:11] != '0), m_axis_tuser == ST_FOUND)
  // An insert always leaves at least one entry.
  `ASSERT_IMPL(a_insert_count, clk, rst,
               m_axis_tvalid && (m_axis_tuser == ST_INSERTED), m_axis_tdata[85:75] != '0)

endmodule
